// ----- rtl/core/sha256r_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 register engine package
// Offsets, command codes, round constants and round functions.
// ----------------------------------------------------------------------------
package sha256r_pkg;

	localparam logic [25:0] OFS_CTRL      = 26'h000;
	localparam logic [25:0] OFS_INFO      = 26'h008;
	localparam logic [25:0] OFS_MSG_FIRST = 26'h010;
	localparam logic [25:0] OFS_MSG_LAST  = 26'h04C;
	localparam logic [25:0] OFS_DIG_FIRST = 26'h060;
	localparam logic [25:0] OFS_DIG_LAST  = 26'h07C;
	localparam logic [31:0] INFO_VALUE    = 32'h0000_0100;
	localparam logic [31:0] CMD_INIT_A    = 32'h0000_0000;
	localparam logic [31:0] CMD_INIT_B    = 32'h0000_0010;
	localparam logic [31:0] CMD_RUN_A     = 32'h0000_000A;
	localparam logic [31:0] CMD_RUN_B     = 32'h0000_000E;

	// Read source select
	localparam logic [2:0] RK_ZERO = 3'd0;
	localparam logic [2:0] RK_INFO = 3'd1;
	localparam logic [2:0] RK_DIG  = 3'd2;

	// Datapath operation codes
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_MSG   = 3'd1,
		OP_INIT  = 3'd2,
		OP_LOAD  = 3'd3,
		OP_ROUND = 3'd4,
		OP_ADD   = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] rnd;
	} dp_cmd_t;

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- rtl/core/sha256r_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-256 register engine controller
// Decodes accesses, sequences the 64 rounds and the final add, times results.
// ----------------------------------------------------------------------------
module sha256r_ctrl
	import sha256r_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        mode,
	input  logic [25:0] offset,
	input  logic [31:0] write_data,
	output logic        busy,
	output logic        done,
	output logic        bad_access,
	output logic        rd_en,
	output logic [2:0]  rd_sel,
	output logic [2:0]  rd_kind,
	output logic [3:0]  msg_idx,
	output dp_cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LOAD  = 4'b0010,
		S_ROUND = 4'b0100,
		S_ADD   = 4'b1000
	} state_t;

	state_t     state_q;
	logic [5:0] rnd_q;
	logic       done_q, bad_q;

	logic aligned, in_msg, in_dig, is_init, is_run, acc;
	logic [25:0] dig_rel, msg_rel;

	assign acc     = start && !busy;
	assign aligned = offset[1:0] == 2'b00;
	assign in_msg  = aligned && offset >= OFS_MSG_FIRST && offset <= OFS_MSG_LAST;
	assign in_dig  = aligned && offset >= OFS_DIG_FIRST && offset <= OFS_DIG_LAST;
	assign is_init = write_data == CMD_INIT_A || write_data == CMD_INIT_B;
	assign is_run  = write_data == CMD_RUN_A || write_data == CMD_RUN_B;
	assign dig_rel = offset - OFS_DIG_FIRST;
	assign msg_rel = offset - OFS_MSG_FIRST;
	assign rd_sel  = dig_rel[4:2];
	assign msg_idx = msg_rel[5:2];
	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign bad_access = bad_q;
	assign rd_en   = acc;

	// Decode the read source; writes always return zero
	always_comb begin
		if (mode) rd_kind = RK_ZERO;
		else if (offset == OFS_CTRL) rd_kind = RK_ZERO;
		else if (offset == OFS_INFO) rd_kind = RK_INFO;
		else if (in_dig) rd_kind = RK_DIG;
		else rd_kind = RK_ZERO;
	end

	// Issue datapath commands
	always_comb begin
		cmd.op  = OP_NONE;
		cmd.rnd = rnd_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && mode) begin
					if (offset == OFS_CTRL && is_init) cmd.op = OP_INIT;
					else if (offset == OFS_CTRL && is_run) cmd.op = OP_LOAD;
					else if (in_msg) cmd.op = OP_MSG;
				end
			end
			S_ROUND: cmd.op = OP_ROUND;
			S_ADD:   cmd.op = OP_ADD;
			default: cmd.op = OP_NONE;
		endcase
	end

	// Advance the sequencer and time the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			bad_q  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (mode && offset == OFS_CTRL && is_run) begin
							state_q <= S_ROUND;
							rnd_q   <= '0;
						end else begin
							done_q <= 1'b1;
							if (mode)
								bad_q <= !((offset == OFS_CTRL && is_init) ||
									offset == OFS_INFO || in_msg);
							else
								bad_q <= !(offset == OFS_CTRL || offset == OFS_INFO ||
									in_dig);
						end
					end
				end
				S_LOAD: state_q <= S_ROUND;
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/sha256r_dp.sv -----
// ----------------------------------------------------------------------------
// SHA-256 register engine datapath
// Message and digest words, rolling schedule window and one round per cycle.
// ----------------------------------------------------------------------------
module sha256r_dp
	import sha256r_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [3:0]  msg_idx,
	input  logic [31:0] write_data,
	input  logic        rd_en,
	input  logic [2:0]  rd_sel,
	input  logic [2:0]  rd_kind,
	input  logic        done,
	input  logic        bad_access,
	output logic [31:0] read_data
);

	logic [31:0] msg_q [16];
	logic [31:0] dig_q [8];
	logic [31:0] w_q   [16];
	logic [31:0] v_q   [8];
	logic [31:0] rd_q;

	logic [31:0] s0, s1, w_new, big0, big1, mj, chs, t1, t2;

	// Schedule and round arithmetic
	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		mj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		chs   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + big1 + chs + ROUND_K[cmd.rnd] + w_q[0];
		t2    = big0 + mj;
	end

	// Hold architectural words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) msg_q[i] <= '0;
			for (int i = 0; i < 8; i++) dig_q[i] <= '0;
		end else begin
			case (cmd.op)
				OP_MSG:  msg_q[msg_idx] <= write_data;
				OP_INIT: for (int i = 0; i < 8; i++) dig_q[i] <= init_hash(3'(i));
				OP_ADD:  for (int i = 0; i < 8; i++) dig_q[i] <= dig_q[i] + v_q[i];
				default: ;
			endcase
		end
	end

	// Advance working variables and schedule window
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				for (int i = 0; i < 16; i++) w_q[i] <= msg_q[i];
				for (int i = 0; i < 8; i++) v_q[i] <= dig_q[i];
			end
			OP_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				for (int i = 1; i < 8; i++) v_q[i] <= v_q[i-1];
				v_q[4] <= v_q[3] + t1;
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	// Capture read word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_q <= '0;
		else if (rd_en) begin
			case (rd_kind)
				RK_INFO: rd_q <= INFO_VALUE;
				RK_DIG:  rd_q <= dig_q[rd_sel];
				default: rd_q <= '0;
			endcase
		end else if (cmd.op != OP_NONE) rd_q <= '0;
	end

	assign read_data = (done && !bad_access) ? rd_q : '0;

endmodule

// ----- rtl/core/sha256_hash_engine_registers.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hash engine registers (top level)
// Register access window around a one-round-per-cycle compression core.
// ----------------------------------------------------------------------------
// Reads and plain writes give their result strobe in the cycle after start.
// A compression command runs 64 rounds, then the digest add, then the strobe.
// Throughput: one access per cycle, no new compression until the last is done;
// busy gates start. Reset clears digest and message words; results cannot stall.
module sha256_hash_engine_registers
	import sha256r_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [25:0] offset,
	input  logic [31:0] write_data,
	output logic        done,
	output logic [31:0] read_data,
	output logic        bad_access
);

	dp_cmd_t    cmd;
	logic       rd_en;
	logic [2:0] rd_sel, rd_kind;
	logic [3:0] msg_idx;

	sha256r_ctrl u_ctrl (
		.clk, .arst_n, .start, .mode, .offset, .write_data,
		.busy, .done, .bad_access, .rd_en, .rd_sel, .rd_kind, .msg_idx, .cmd
	);

	sha256r_dp u_dp (
		.clk, .arst_n, .cmd, .msg_idx, .write_data, .rd_en, .rd_sel, .rd_kind,
		.done, .bad_access, .read_data
	);

endmodule

// ----- rtl/core/sha256r_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 register engine checker
// Port-level timing checks, bound to the top level.
// ----------------------------------------------------------------------------
module sha256r_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] read_data,
	input logic        bad_access
);

	// A bad access returns zero data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_access |-> read_data == '0) else $error("bad access data");

	// Flags only appear with the strobe
	a_bad_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		bad_access |-> done) else $error("stray bad flag");

	// An accepted item makes the engine busy or gives the strobe
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("item dropped");

	// Strobe ends the busy window
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("strobe while busy");

endmodule

bind sha256_hash_engine_registers sha256r_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .read_data, .bad_access
);
